/* src/nih_pkg.sv */
// Package: shared types and constants of the name interning hash table.
package nih_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_TOOLONG  = 2'd3;

  localparam logic [0:0] REG_ENTRY_LIMIT = 1'd0;
  localparam logic [7:0] LIMIT_RESET     = 8'd180;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_COPY,
    S_DONE
  } state_t;

endpackage

/* src/nih_fnv_mul.sv */
// FNV prime multiplier: the running hash times the prime, split into two registered partial products.
module nih_fnv_mul
  import nih_pkg::*;
(
  input  logic        clk,
  input  logic        go,
  input  logic [31:0] a,
  output logic [31:0] p
);

  logic [31:0] lo_r;
  logic [15:0] hi_r;

  always_ff @(posedge clk) begin
    if (go) begin
      lo_r <= a * {16'd0, FNV_PRIME[15:0]};
      hi_r <= a[15:0] * FNV_PRIME[31:16];
    end
  end

  assign p = lo_r + {hi_r, 16'd0};

endmodule

/* src/name_intern_hash_table.sv */
// Top level: name interning hash table with linear probing over FNV-1a hashes.
//
//   channel | ports                                   | handshake
//   input   | in_name_kind/byte/empty_name/last_byte  | start, busy
//   result  | out_status, out_slot, out_name_hash     | out_valid, one cycle
//   config  | cfg_psel ... cfg_prdata                 | APB read/write, pready high
//
// A byte beat passes S_IDLE and S_MUL (hash multiply into hash_r). A final beat then
// probes slots one at a time (S_PROBE_RD, S_PROBE_CHK) through the slot store's read
// port and compares name bytes one at a time (S_CMP_RD, S_CMP_CHK); an insert copies
// one byte per cycle. Reset is synchronous; after reset a clearing pass over every slot
// empties the slot-used map with busy high. The receiver cannot stall.
module name_intern_hash_table
  import nih_pkg::*;
#(
  parameter int SLOTS    = 256,
  parameter int MAX_NAME = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_name_kind,
  input  logic [7:0]  in_name_byte,
  input  logic        in_empty_name,
  input  logic        in_last_byte,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_slot,
  output logic [31:0] out_name_hash,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SW = $clog2(SLOTS);
  localparam int NW = $clog2(MAX_NAME);
  localparam int LW = $clog2(MAX_NAME + 1);
  localparam int BW = SW + NW;

  state_t state_r, state_nxt;

  logic [7:0]    limit_r;
  logic [8:0]    count_r;
  logic [31:0]   hash_r;
  logic [LW-1:0] len_r;
  logic          over_r, kind_r, last_r;
  logic [SW-1:0] slot_r;
  logic [SW:0]   visits_r;
  logic [LW-1:0] idx_r;
  logic          clr_r;
  logic [SW:0]   clr_cnt_r;
  logic          ins_r, found_r;

  logic [7:0]    inc_mem [MAX_NAME];
  logic [7:0]    inc_rd_r;
  logic [7:0]    name_mem [SLOTS*MAX_NAME];
  logic [7:0]    name_rd_r;
  logic          used_mem [SLOTS];
  logic          used_rd_r;
  logic [31:0]   hash_mem [SLOTS];
  logic [31:0]   hash_rd_r;
  logic          kind_mem [SLOTS];
  logic          kind_rd_r;
  logic [LW-1:0] len_mem [SLOTS];
  logic [LW-1:0] len_rd_r;

  logic [31:0]   mul_p;
  logic          mul_go;
  logic          acc;
  logic          cfg_wr;
  logic          meta_hit;
  logic          ins_ok;
  logic          ins_go;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[1:1] == REG_ENTRY_LIMIT) ? {24'd0, limit_r} : 32'd0;

  assign busy = clr_r || (state_r != S_IDLE);
  assign acc  = start && !busy;
  assign mul_go = acc && !in_empty_name;

  assign meta_hit = kind_rd_r == kind_r && hash_rd_r == hash_r && len_rd_r == len_r;
  assign ins_ok   = {1'b0, count_r[7:0]} < {1'b0, limit_r} && !count_r[8];
  assign ins_go   = state_r == S_PROBE_CHK && !used_rd_r && ins_ok;

  nih_fnv_mul u_mul (
    .clk (clk),
    .go  (mul_go),
    .a   (hash_r ^ {24'd0, in_name_byte}),
    .p   (mul_p)
  );

  logic [BW-1:0] name_addr;
  assign name_addr = {slot_r, idx_r[NW-1:0]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (!in_empty_name) state_nxt = S_MUL;
          else if (over_r) state_nxt = S_DONE;
          else state_nxt = S_PROBE_RD;
        end
      end
      S_MUL: begin
        if (!last_r) state_nxt = S_IDLE;
        else if (over_r) state_nxt = S_DONE;
        else state_nxt = S_PROBE_RD;
      end
      S_PROBE_RD: state_nxt = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (!used_rd_r) begin
          state_nxt = (ins_ok && len_r != '0) ? S_COPY : S_DONE;
        end else if (meta_hit) begin
          state_nxt = (len_r == '0) ? S_DONE : S_CMP_RD;
        end else if (visits_r + 1'b1 >= (SW+1)'(SLOTS)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PROBE_RD;
        end
      end
      S_CMP_RD: state_nxt = S_CMP_CHK;
      S_CMP_CHK: begin
        if (name_rd_r != inc_rd_r) begin
          state_nxt = (visits_r + 1'b1 >= (SW+1)'(SLOTS)) ? S_DONE : S_PROBE_RD;
        end else if (idx_r + 1'b1 == len_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CMP_RD;
        end
      end
      S_COPY: if (idx_r == len_r) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      limit_r       <= LIMIT_RESET;
      count_r       <= '0;
      hash_r        <= FNV_BASIS;
      len_r         <= '0;
      over_r        <= 1'b0;
      kind_r        <= 1'b0;
      last_r        <= 1'b0;
      out_valid     <= 1'b0;
      out_status    <= ST_FOUND;
      out_slot      <= 8'd0;
      out_name_hash <= 32'd0;
      clr_r         <= 1'b1;
      clr_cnt_r     <= '0;
      visits_r      <= '0;
      idx_r         <= '0;
      slot_r        <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_DONE);
      if (cfg_wr && cfg_paddr[1:1] == REG_ENTRY_LIMIT) limit_r <= cfg_pwdata[7:0];
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (SW+1)'(SLOTS - 1)) clr_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (len_r == '0 && !over_r) kind_r <= in_name_kind;
            last_r <= in_last_byte;
            if (!in_empty_name) begin
              if (len_r < LW'(MAX_NAME)) len_r <= len_r + 1'b1;
              else over_r <= 1'b1;
            end else begin
              slot_r   <= hash_r[SW-1:0];
              visits_r <= '0;
            end
          end
        end
        S_MUL: begin
          hash_r   <= mul_p;
          slot_r   <= mul_p[SW-1:0];
          visits_r <= '0;
        end
        S_PROBE_RD: idx_r <= '0;
        S_PROBE_CHK: begin
          if (state_nxt == S_PROBE_RD) begin
            slot_r   <= slot_r + 1'b1;
            visits_r <= visits_r + 1'b1;
          end
        end
        S_CMP_CHK: begin
          if (state_nxt == S_PROBE_RD) begin
            slot_r   <= slot_r + 1'b1;
            visits_r <= visits_r + 1'b1;
          end else if (state_nxt == S_CMP_RD) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_COPY: idx_r <= idx_r + 1'b1;
        S_DONE: begin
          out_name_hash <= hash_r;
          if (over_r) begin
            out_status <= ST_TOOLONG;
            out_slot   <= 8'd0;
          end else if (ins_r) begin
            out_status <= ST_INSERTED;
            out_slot   <= 8'(slot_r);
            count_r    <= count_r + 1'b1;
          end else if (found_r) begin
            out_status <= ST_FOUND;
            out_slot   <= 8'(slot_r);
          end else begin
            out_status <= ST_FULL;
            out_slot   <= 8'd0;
          end
          hash_r <= FNV_BASIS;
          len_r  <= '0;
          over_r <= 1'b0;
          kind_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_r   <= 1'b0;
      found_r <= 1'b0;
    end else if (state_r == S_IDLE) begin
      ins_r   <= 1'b0;
      found_r <= 1'b0;
    end else if (ins_go) begin
      ins_r <= 1'b1;
    end else if (state_r == S_PROBE_CHK && used_rd_r && meta_hit && len_r == '0) begin
      found_r <= 1'b1;
    end else if (state_r == S_CMP_CHK && name_rd_r == inc_rd_r && idx_r + 1'b1 == len_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) used_mem[clr_cnt_r[SW-1:0]] <= 1'b0;
    else if (ins_go) used_mem[slot_r] <= 1'b1;
    if (ins_go) begin
      hash_mem[slot_r] <= hash_r;
      kind_mem[slot_r] <= kind_r;
      len_mem[slot_r]  <= len_r;
    end
    used_rd_r <= used_mem[slot_r];
    hash_rd_r <= hash_mem[slot_r];
    kind_rd_r <= kind_mem[slot_r];
    len_rd_r  <= len_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (acc && !in_empty_name && len_r < LW'(MAX_NAME)) inc_mem[len_r[NW-1:0]] <= in_name_byte;
    inc_rd_r <= inc_mem[idx_r[NW-1:0]];
  end

  logic copy_wr_r;
  logic [BW-1:0] copy_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) copy_wr_r <= 1'b0;
    else copy_wr_r <= (state_r == S_COPY) && (idx_r != len_r);
    copy_addr_r <= name_addr;
    if (copy_wr_r) name_mem[copy_addr_r] <= inc_rd_r;
    name_rd_r <= name_mem[name_addr];
  end

endmodule

/* test/name_intern_hash_table_tb.sv */
// Testbench: self-checking stimulus and prediction for the name interning hash table.
`timescale 1ns / 100ps
module name_intern_hash_table_tb
  import nih_pkg::*;
();

  localparam int TBL = 256;
  localparam int MAXN = 32;
  localparam int POOL = 64;
  localparam int IDLE_LIMIT = 60000;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [31:0] hash;
  } intern_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_name_kind = 1'b0;
  logic [7:0] in_name_byte = 8'd0;
  logic in_empty_name = 1'b0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic [1:0] out_status;
  logic [7:0] out_slot;
  logic [31:0] out_name_hash;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = 2'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  name_intern_hash_table dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the table and of the name being received.
  bit          tbl_used [TBL];
  logic [31:0] tbl_hash [TBL];
  logic        tbl_kind [TBL];
  int          tbl_len [TBL];
  logic [7:0]  tbl_bytes [TBL][MAXN];
  int          live_entries;
  logic [7:0]  limit_reg;
  logic [31:0] cur_hash;
  int          cur_len;
  bit          cur_over;
  logic        cur_kind;
  logic [7:0]  cur_bytes [MAXN];

  intern_t     pending_q[$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          results_seen = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int          burst_left = 0;
  int          idle_cycles = 0;

  logic [7:0]  pool_bytes [POOL][40];
  int          pool_len [POOL];
  logic        pool_kind [POOL];

  function automatic void clear_name();
    cur_hash = FNV_BASIS;
    cur_len = 0;
    cur_over = 1'b0;
    cur_kind = 1'b0;
  endfunction

  function automatic bit intern_name(input logic kind, input logic [7:0] b,
                                     input logic empty, input logic last,
                                     output intern_t r);
    int idx;
    bit hit;
    if (cur_len == 0 && !cur_over) cur_kind = kind;
    if (!empty) begin
      cur_hash = (cur_hash ^ {24'd0, b}) * FNV_PRIME;
      if (cur_len < MAXN) begin
        cur_bytes[cur_len] = b;
        cur_len++;
      end else begin
        cur_over = 1'b1;
      end
    end
    if (!empty && !last) return 1'b0;
    r.status = ST_FULL;
    r.slot = 8'd0;
    r.hash = cur_hash;
    if (cur_over) begin
      r.status = ST_TOOLONG;
    end else begin
      idx = cur_hash % TBL;
      for (int n = 0; n < TBL; n++) begin
        if (!tbl_used[idx]) begin
          if (live_entries < limit_reg) begin
            tbl_used[idx] = 1'b1;
            tbl_hash[idx] = cur_hash;
            tbl_kind[idx] = cur_kind;
            tbl_len[idx] = cur_len;
            for (int k = 0; k < cur_len; k++) tbl_bytes[idx][k] = cur_bytes[k];
            live_entries++;
            r.status = ST_INSERTED;
            r.slot = 8'(idx);
          end
          break;
        end
        hit = tbl_kind[idx] == cur_kind && tbl_hash[idx] == cur_hash &&
              tbl_len[idx] == cur_len;
        for (int k = 0; k < cur_len && hit; k++)
          if (tbl_bytes[idx][k] != cur_bytes[k]) hit = 1'b0;
        if (hit) begin
          r.status = ST_FOUND;
          r.slot = 8'(idx);
          break;
        end
        idx = (idx + 1) % TBL;
      end
    end
    clear_name();
    return 1'b1;
  endfunction

  function automatic void report(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      status_seen[out_status]++;
      if (pending_q.size() == 0) begin
        report("unexpected result status", 32'hx, out_status);
      end else begin
        intern_t want;
        want = pending_q.pop_front();
        if (out_status !== want.status) report("status", want.status, out_status);
        if (out_slot !== want.slot) report("slot", want.slot, out_slot);
        if (out_name_hash !== want.hash) report("name hash", want.hash, out_name_hash);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_q.size());
      $display("name_intern_hash_table test failed");
      $finish;
    end
  end

  // Sends one beat; start stays high so that a burst runs back to back.
  task automatic send_beat(input logic kind, input logic [7:0] b,
                           input logic empty, input logic last);
    intern_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      @(negedge clk);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    start <= 1'b1;
    in_name_kind <= kind;
    in_name_byte <= b;
    in_empty_name <= empty;
    in_last_byte <= last;
    do @(posedge clk); while (busy);
    beats_sent++;
    if (intern_name(kind, b, empty, last, r)) pending_q.push_back(r);
  endtask

  // Ends a name either by the last-byte flag or by a trailing empty beat.
  task automatic send_name(input int p, input bit empty_end);
    int n;
    n = pool_len[p];
    if (n == 0) begin
      send_beat(pool_kind[p], 8'($urandom), 1'b1, 1'($urandom));
      return;
    end
    for (int k = 0; k < n; k++)
      send_beat(k == 0 ? pool_kind[p] : 1'($urandom), pool_bytes[p][k], 1'b0,
                !empty_end && k == n - 1);
    if (empty_end) send_beat(1'($urandom), 8'($urandom), 1'b1, 1'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'(4 * REG_ENTRY_LIMIT);
    cfg_pwdata <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    limit_reg = value;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[7:0] !== value) report("entry limit readback", value, cfg_prdata);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic make_pool_entry(input int p, input int n);
    pool_len[p] = n;
    pool_kind[p] = 1'($urandom);
    for (int k = 0; k < n; k++) pool_bytes[p][k] = 8'($urandom);
  endtask

  task automatic test_directed();
    pool_len[0] = 0; pool_kind[0] = 1'b0;
    pool_len[1] = 0; pool_kind[1] = 1'b1;
    pool_len[2] = 1; pool_kind[2] = 1'b0; pool_bytes[2][0] = 8'h00;
    pool_len[3] = 1; pool_kind[3] = 1'b1; pool_bytes[3][0] = 8'hFF;
    make_pool_entry(4, MAXN);
    make_pool_entry(5, MAXN + 1);
    make_pool_entry(6, 3);
    send_name(0, 1'b0);
    send_name(1, 1'b0);
    send_name(0, 1'b0);
    send_name(2, 1'b0);
    send_name(3, 1'b0);
    send_name(3, 1'b0);
    send_name(4, 1'b0);
    send_name(4, 1'b1);
    send_name(5, 1'b0);
    send_name(6, 1'b1);
    pool_kind[6] = ~pool_kind[6];
    send_name(6, 1'b0);
    drain();
  endtask

  task automatic test_limits();
    write_limit(8'd1);
    make_pool_entry(7, 5);
    send_name(7, 1'b0);
    send_name(2, 1'b0);
    drain();
    write_limit(8'd0);
    send_name(7, 1'b0);
    send_name(4, 1'b0);
    send_name(0, 1'b1);
    drain();
    write_limit(8'd255);
    send_name(7, 1'b0);
    drain();
  endtask

  task automatic test_random(input int beats);
    int p;
    for (int p2 = 8; p2 < POOL; p2++)
      make_pool_entry(p2, $urandom_range(0, 9) == 0 ? $urandom_range(28, 40)
                                                    : $urandom_range(0, 6));
    while (beats_sent < beats) begin
      case ($urandom_range(0, 9))
        0: send_beat(1'($urandom), 8'($urandom), 1'($urandom_range(0, 5) == 0),
                     1'($urandom_range(0, 3) == 0));
        1: begin
          p = $urandom_range(8, POOL - 1);
          make_pool_entry(p, $urandom_range(0, 8));
          send_name(p, 1'($urandom));
        end
        default: send_name($urandom_range(0, POOL - 1), $urandom_range(0, 4) == 0);
      endcase
    end
    send_beat(1'b0, 8'd0, 1'b1, 1'b1);
    drain();
  endtask

  initial begin
    for (int i = 0; i < TBL; i++) tbl_used[i] = 1'b0;
    live_entries = 0;
    limit_reg = LIMIT_RESET;
    clear_name();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_limits();
    test_random(900);
    write_limit(8'($urandom_range(1, 254)));
    test_random(1600);
    $display("%0d beats sent, %0d results: %0d found, %0d inserted, %0d refused, %0d too long",
             beats_sent, results_seen, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3]);
    $display("table holds %0d entries, %0d mismatches", live_entries, mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("name_intern_hash_table test passed");
    end else begin
      $display("name_intern_hash_table test failed");
    end
    $finish;
  end

endmodule
